@@ sv/quaternion_orientation_steering_defines.svh @@
// Assertion macros of the verification collateral of the steering block.
// Depends on nothing; included by qos_checker, which carries the concurrent assertions.
`ifndef QUATERNION_ORIENTATION_STEERING_DEFINES_SVH
`define QUATERNION_ORIENTATION_STEERING_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QOS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("steering block assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define QOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("steering block assertion failed");

`endif

@@ sv/qos_pkg.sv @@
// Shared types, constants and arithmetic helpers of the quaternion steering block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package qos_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ACC_W     = 35;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 64;

	localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
	localparam logic signed [15:0] Q_MIN = 16'sh8000;
	localparam logic signed [15:0] IDLE_W = (FRAC_BITS >= 15) ? Q_MAX : 16'(1 << FRAC_BITS);

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(Q_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(Q_MIN);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_RESET  = 1'b1;

	localparam logic REG_CAL = 1'b0;
	localparam logic REG_INV = 1'b1;

	// Terms of each Hamilton product component that are subtracted.
	localparam logic [3:0] NEG_MASK [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PROD_STEER,
		PROD_CONJ,
		PROD_CAL
	} prod_t;

	typedef struct packed {
		logic       valid;
		prod_t      prod;
		logic [1:0] comp;
		logic [1:0] term;
	} issue_t;

	typedef struct packed {
		logic busy;
		logic load;
	} ctrl_sts_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic       neg;
		logic [1:0] comp;
	} mac_ctl_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        comp;
		logic signed [15:0] value;
	} mac_res_t;

	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
		return (v == Q_MIN) ? Q_MAX : -v;
	endfunction

	// Round half up at the binary point, then clamp to the 16-bit range.
	function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sum;
		logic signed [ACC_W-1:0] sh;
		sum = acc + RND_HALF;
		sh  = sum >>> FRAC_BITS;
		if (sh > SAT_HI) begin
			return Q_MAX;
		end else if (sh < SAT_LO) begin
			return Q_MIN;
		end
		return sh[15:0];
	endfunction

endpackage

@@ sv/quaternion_orientation_steering.sv @@
// Top level of the quaternion orientation steering block: register port,
// quaternion state, operand selection and output register.
// Depends on qos_pkg, qos_ctrl and qos_mac.
`timescale 1ns / 1ps

// A raw sample (opcode 0) is turned into conj(cal) * (idle * raw) * cal in Q2.14,
// rounded and saturated after each product, with x, y and z negated as invert_axes
// selects. One 16x16 multiplier is shared by all 48 multiply-accumulate steps, so a
// sample holds the input stalled while the block issues three products, drains the
// multiplier pipeline after each and loads the result. If the previous result has
// not been taken yet, the block waits before that load. A reset-orientation beat
// (opcode 1) does not stall the input; it stores the conjugate of the last raw sample
// as the idle quaternion and gives no result. Registers: cal_quat at byte address 0
// (64 bits), invert_axes at address 8; write them only while idle.
module quaternion_orientation_steering (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qos_pkg::PADDR_W-1:0]  paddr,
	input  logic [qos_pkg::PDATA_W-1:0]  pwdata,
	output logic [qos_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         smp_valid,
	output logic                         smp_stall,
	input  logic                         opcode,
	input  logic signed [15:0]           raw_w,
	input  logic signed [15:0]           raw_x,
	input  logic signed [15:0]           raw_y,
	input  logic signed [15:0]           raw_z,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [15:0]           out_w,
	output logic signed [15:0]           out_x,
	output logic signed [15:0]           out_y,
	output logic signed [15:0]           out_z
);
	import qos_pkg::*;

	logic [0:3][15:0]   cal_q;
	logic [2:0]         inv_q;
	logic [0:3][15:0]   raw_q;
	logic [0:3][15:0]   idle_q;
	logic [0:3][15:0]   t_q;
	logic signed [15:0] nxt_q [3];
	logic signed [15:0] out_w_q;
	logic signed [15:0] out_x_q;
	logic signed [15:0] out_y_q;
	logic signed [15:0] out_z_q;
	logic               res_valid_q;

	logic               cfg_wr;
	logic               smp_acc;
	logic               start;
	logic               out_free;
	issue_t             issue;
	ctrl_sts_t          sts;
	mac_ctl_t           mac_ctl;
	mac_res_t           mac_res;
	logic [1:0]         b_idx;
	logic [1:0]         t_addr;
	logic [1:0]         c_addr;
	logic signed [15:0] t_rd;
	logic signed [15:0] c_rd;
	logic signed [15:0] op_a;
	logic signed [15:0] op_b;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign smp_stall = sts.busy;
	assign smp_acc  = smp_valid & ~smp_stall;
	assign start    = smp_acc & (opcode == OP_SAMPLE);
	assign out_free = ~res_valid_q | ~res_stall;

	always_comb begin
		unique case (paddr[3])
			REG_CAL: prdata = cal_q;
			REG_INV: prdata = {{(PDATA_W - 3){1'b0}}, inv_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= {IDLE_W, 48'h0} & 64'h0 | 64'h4000_0000_0000_0000;
			inv_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_CAL: cal_q <= pwdata;
				REG_INV: inv_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// The idle quaternion comes out of reset as identity and the last raw sample as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q  <= '0;
			idle_q <= {IDLE_W, 48'h0};
		end else if (smp_acc) begin
			if (opcode == OP_SAMPLE) begin
				raw_q <= {raw_w, raw_x, raw_y, raw_z};
			end else begin
				idle_q <= {raw_q[0], neg_sat(raw_q[1]), neg_sat(raw_q[2]),
					neg_sat(raw_q[3])};
			end
		end
	end

	qos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.issue    (issue),
		.sts      (sts)
	);

	// Term k of component i multiplies a[k] by b[i ^ k].
	assign b_idx  = issue.comp ^ issue.term;
	assign t_addr = (issue.prod == PROD_CAL)  ? issue.term : b_idx;
	assign c_addr = (issue.prod == PROD_CONJ) ? issue.term : b_idx;
	assign t_rd   = t_q[t_addr];
	assign c_rd   = cal_q[c_addr];

	always_comb begin
		case (issue.prod)
			PROD_STEER: begin
				op_a = idle_q[issue.term];
				op_b = raw_q[b_idx];
			end
			PROD_CONJ: begin
				op_a = (issue.term == 2'd0) ? c_rd : neg_sat(c_rd);
				op_b = t_rd;
			end
			PROD_CAL: begin
				op_a = t_rd;
				op_b = c_rd;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		mac_ctl.valid = issue.valid;
		mac_ctl.first = (issue.term == 2'd0);
		mac_ctl.last  = (issue.term == 2'd3);
		mac_ctl.neg   = NEG_MASK[issue.comp][issue.term];
		mac_ctl.comp  = issue.comp;
	end

	qos_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl    (mac_ctl),
		.res    (mac_res)
	);

	// Components of the product in flight collect here; the last one moves the
	// whole quaternion into t_q so the next product can read it.
	always_ff @(posedge clk) begin
		if (mac_res.valid) begin
			case (mac_res.comp)
				2'd0: nxt_q[0] <= mac_res.value;
				2'd1: nxt_q[1] <= mac_res.value;
				2'd2: nxt_q[2] <= mac_res.value;
				default: t_q <= {nxt_q[0], nxt_q[1], nxt_q[2], mac_res.value};
			endcase
		end
		if (sts.load) begin
			out_w_q <= t_q[0];
			out_x_q <= inv_q[0] ? neg_sat(t_q[1]) : t_q[1];
			out_y_q <= inv_q[1] ? neg_sat(t_q[2]) : t_q[2];
			out_z_q <= inv_q[2] ? neg_sat(t_q[3]) : t_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (sts.load) begin
			res_valid_q <= 1'b1;
		end else if (~res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign out_w     = out_w_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

endmodule

@@ sv/qos_mac.sv @@
// Shared multiply-accumulate unit: one 16x16 multiplier, a signed accumulator
// and the round/saturate step. Depends on qos_pkg.
`timescale 1ns / 1ps

module qos_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  op_a,
	input  logic signed [15:0]  op_b,
	input  qos_pkg::mac_ctl_t   ctl,
	output qos_pkg::mac_res_t   res
);
	import qos_pkg::*;

	logic signed [31:0]      prod_s1;
	mac_ctl_t                ctl_s1;
	logic signed [ACC_W-1:0] acc_s2;
	mac_ctl_t                ctl_s2;
	logic signed [ACC_W-1:0] ext;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	assign ext    = ACC_W'(prod_s1);
	assign addend = ctl_s1.neg ? -ext : ext;
	assign base   = ctl_s1.first ? '0 : acc_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctl_s1.valid) begin
			acc_s2 <= base + addend;
		end
	end

	always_comb begin
		res.valid = ctl_s2.valid & ctl_s2.last;
		res.comp  = ctl_s2.comp;
		res.value = round_sat(acc_s2);
	end

endmodule

@@ sv/qos_ctrl.sv @@
// Sequencer of the steering block: walks three Hamilton products, four terms
// per component, and hands the finished result to the output register.
// Depends on qos_pkg.
`timescale 1ns / 1ps

module qos_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 out_free,
	output qos_pkg::issue_t      issue,
	output qos_pkg::ctrl_sts_t   sts
);
	import qos_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] cnt_q;
	prod_t      prod_q;
	logic       drn_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (cnt_q == 4'hF) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drn_q) state_d = (prod_q == PROD_CAL) ? ST_DONE : ST_ISSUE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		issue.valid = (state_q == ST_ISSUE);
		issue.prod  = prod_q;
		issue.comp  = cnt_q[3:2];
		issue.term  = cnt_q[1:0];
		sts.busy    = (state_q != ST_IDLE);
		sts.load    = (state_q == ST_DONE) & out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			prod_q  <= PROD_STEER;
			drn_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					prod_q <= PROD_STEER;
					drn_q  <= 1'b0;
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + 4'd1;
				end
				ST_DRAIN: begin
					drn_q <= ~drn_q;
					if (drn_q) begin
						unique case (prod_q)
							PROD_STEER: prod_q <= PROD_CONJ;
							PROD_CONJ:  prod_q <= PROD_CAL;
							default:    prod_q <= PROD_CAL;
						endcase
					end
				end
				default: begin
					drn_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ sv/qos_checker.sv @@
// Port-level checks of the quaternion steering block, bound to its top level.
// Depends on quaternion_orientation_steering_defines.svh.
`timescale 1ns / 1ps
`include "quaternion_orientation_steering_defines.svh"

module qos_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               smp_valid,
	input logic               smp_stall,
	input logic               opcode,
	input logic               res_valid,
	input logic               res_stall,
	input logic signed [15:0] out_w,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_z
);

	logic [63:0] res_data;

	assign res_data = {out_w, out_x, out_y, out_z};

	// A stalled result beat keeps its payload.
	`QOS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_data))

	// A raw sample occupies the shared multiplier, so the input stalls right after.
	`QOS_ASSERT_NEXT(a_sample_busy, clk, arst_n, smp_valid && !smp_stall && !opcode, smp_stall)

	// A reset-orientation beat leaves the input unstalled in the cycle after it.
	`QOS_ASSERT_NEXT(a_reset_quick, clk, arst_n, smp_valid && !smp_stall && opcode, !smp_stall)

	// A new result appears only as the sample that made it completes.
	`QOS_ASSERT_SAME(a_res_at_end, clk, arst_n, $rose(res_valid), $fell(smp_stall))

endmodule

bind quaternion_orientation_steering qos_checker u_qos_checker (.*);
